/* rtl/gprc_pkg.sv */
// Shared types and constants for the grid path residue counter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package gprc_pkg;

  localparam int CNT_W = 30;                      // path count width
  localparam int VAL_W = 8;                       // cell value width
  localparam int RM_W  = 7;                       // residue_modulus register width
  localparam int RW_W  = 9;                       // row_width register width
  localparam logic [CNT_W-1:0] COUNT_MOD = 30'd1000000007;

  localparam logic REG_RESIDUE_MODULUS = 1'b0;    // register index by paddr[2]
  localparam logic REG_ROW_WIDTH       = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_ISSUE,
    ST_RUN,
    ST_HOLD
  } core_state_t;

  typedef struct packed {
    logic idle;   // ready for a new cell beat
    logic done;   // result of a last cell waiting for the output register
  } core_stat_t;

endpackage

`default_nettype wire

/* rtl/gprc_addmod.sv */
// Shared modular adder: (a + b) mod 1000000007 for operands below the modulus.
// Depends on gprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprc_addmod (
  input  logic [gprc_pkg::CNT_W-1:0] a,
  input  logic [gprc_pkg::CNT_W-1:0] b,
  output logic [gprc_pkg::CNT_W-1:0] y
);
  import gprc_pkg::*;

  logic [CNT_W:0] sum;

  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, COUNT_MOD}) begin
      y = CNT_W'(sum - {1'b0, COUNT_MOD});
    end else begin
      y = sum[CNT_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* rtl/gprc_residue.sv */
// Bit-serial restoring remainder: cell value mod k, one bit per cycle.
// Depends on gprc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gprc_residue #(
  parameter int MAX_K = 64,
  localparam int KC_W = $clog2(MAX_K + 1)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gprc_pkg::VAL_W-1:0] value,
  input  logic [KC_W-1:0]            divisor,
  output logic                       busy,
  output logic [KC_W-1:0]            rem
);
  import gprc_pkg::*;

  localparam int STEP_W = $clog2(VAL_W);

  logic [VAL_W-1:0]  sh;
  logic [STEP_W-1:0] step;
  logic [KC_W:0]     trial;

  assign trial = {rem, sh[VAL_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == STEP_W'(VAL_W - 1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      sh   <= value;
      step <= '0;
    end else if (busy) begin
      if (trial >= {1'b0, divisor}) begin
        rem <= KC_W'(trial - {1'b0, divisor});
      end else begin
        rem <= trial[KC_W-1:0];
      end
      sh   <= {sh[VAL_W-2:0], 1'b0};
      step <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/gprc_core.sv */
// Cell sequencer: grid position, line store, left vector and the residue sweep.
// Depends on gprc_pkg, gprc_residue and gprc_addmod.
`timescale 1ns / 1ps
`default_nettype none

module gprc_core #(
  parameter int MAX_COLS = 256,
  parameter int MAX_K    = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gprc_pkg::VAL_W-1:0] cell_value,
  input  logic                       last_cell,
  input  logic [gprc_pkg::RM_W-1:0]  residue_modulus,
  input  logic [gprc_pkg::RW_W-1:0]  row_width,
  input  logic                       push_ok,
  output gprc_pkg::core_stat_t       stat,
  output logic [gprc_pkg::CNT_W-1:0] result
);
  import gprc_pkg::*;

  localparam int K_W     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int KC_W    = $clog2(MAX_K + 1);
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int WC_W    = $clog2(MAX_COLS + 1);
  localparam int STORE_D = MAX_COLS << K_W;
  localparam int SW      = KC_W + 1;

  core_state_t state, state_next;

  // effective configuration
  logic [KC_W-1:0] k_eff;
  logic [WC_W-1:0] w_eff;

  always_comb begin
    if (residue_modulus == '0) begin
      k_eff = KC_W'(1);
    end else if (int'(residue_modulus) > MAX_K) begin
      k_eff = KC_W'(MAX_K);
    end else begin
      k_eff = KC_W'(residue_modulus);
    end
    if (row_width == '0) begin
      w_eff = WC_W'(1);
    end else if (int'(row_width) > MAX_COLS) begin
      w_eff = WC_W'(MAX_COLS);
    end else begin
      w_eff = WC_W'(row_width);
    end
  end

  // grid position
  logic [COL_W-1:0] col_pos;
  logic             first_row;
  logic             wrap;
  logic [COL_W-1:0] col_i;
  logic             first_i;

  assign wrap    = int'(col_pos) >= int'(w_eff);
  assign col_i   = wrap ? '0 : col_pos;
  assign first_i = wrap ? 1'b0 : first_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos   <= '0;
      first_row <= 1'b1;
    end else if (start) begin
      if (last_cell) begin
        col_pos   <= '0;
        first_row <= 1'b1;
      end else if (int'(col_i) + 1 >= int'(w_eff)) begin
        col_pos   <= '0;
        first_row <= 1'b0;
      end else begin
        col_pos   <= col_i + 1'b1;
        first_row <= first_i;
      end
    end
  end

  // per-cell item registers
  logic [COL_W-1:0] col;
  logic             first;
  logic             last;
  logic [KC_W-1:0]  k;

  always_ff @(posedge clk) begin
    if (start) begin
      col   <= col_i;
      first <= first_i;
      last  <= last_cell;
      k     <= k_eff;
    end
  end

  // shift amount
  logic            div_busy;
  logic [KC_W-1:0] div_rem;
  logic [K_W-1:0]  s;

  gprc_residue #(.MAX_K(MAX_K)) u_residue (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .value   (cell_value),
    .divisor (k_eff),
    .busy    (div_busy),
    .rem     (div_rem)
  );

  assign s = div_rem[K_W-1:0];

  // sweep control: follow the rotation cycles, leaders 0, 1, ...
  logic [K_W-1:0]  lead;
  logic [K_W-1:0]  cur;
  logic [KC_W-1:0] cnt;
  logic [SW-1:0]   dsum;
  logic [K_W-1:0]  dst;
  logic            last_step;
  logic            we;
  logic [K_W-1:0]  ra;

  always_comb begin
    dsum = SW'(cur) + SW'(s);
    if (dsum >= SW'(k)) begin
      dst = K_W'(dsum - SW'(k));
    end else begin
      dst = K_W'(dsum);
    end
  end

  assign last_step = int'(cnt) + 1 == int'(k);

  // memories and read data
  logic [CNT_W-1:0] store_mem [STORE_D];
  logic [CNT_W-1:0] left_mem [MAX_K];
  logic [MAX_K-1:0] left_ok;
  logic [CNT_W-1:0] rd_store;
  logic [CNT_W-1:0] rd_left;
  logic             rd_ok;
  logic [CNT_W-1:0] acc;
  logic [CNT_W-1:0] op_a;
  logic [CNT_W-1:0] op_b;
  logic [CNT_W-1:0] msum;

  assign op_a = (col != '0 && rd_ok) ? rd_left : '0;
  assign op_b = first ? '0 : rd_store;

  gprc_addmod u_addmod (
    .a (op_a),
    .b (op_b),
    .y (msum)
  );

  always_comb begin
    if (col == '0 && first) begin
      acc = (cur == '0) ? CNT_W'(1) : '0;  // top-left: one path at its own residue
    end else begin
      acc = msum;
    end
  end

  // read at dst while writing it: old data goes to the next step
  always_ff @(posedge clk) begin
    if (we) begin
      store_mem[{col, dst}] <= acc;
    end
    rd_store <= store_mem[{col, ra}];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      left_mem[dst] <= acc;
    end
    rd_left <= left_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_ok <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        left_ok[dst] <= 1'b1;
      end
      rd_ok <= left_ok[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      lead <= '0;
      cnt  <= '0;
    end else if (state == ST_ISSUE) begin
      cur <= lead;
    end else if (state == ST_RUN) begin
      cnt <= cnt + 1'b1;
      if (dst == lead) begin
        lead <= lead + 1'b1;
        cur  <= lead + 1'b1;
      end else begin
        cur <= dst;
      end
      if (dst == '0) begin
        result <= acc;
      end
    end
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_DIV;
      ST_DIV:   if (!div_busy) state_next = ST_ISSUE;
      ST_ISSUE: state_next = ST_RUN;
      ST_RUN: begin
        if (last_step) begin
          state_next = last ? ST_HOLD : ST_IDLE;
        end
      end
      ST_HOLD:  if (push_ok) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    stat.idle = 1'b0;
    stat.done = 1'b0;
    we        = 1'b0;
    ra        = lead;
    case (state)
      ST_IDLE:  stat.idle = 1'b1;
      ST_ISSUE: ra = lead;
      ST_RUN: begin
        we = 1'b1;
        ra = (dst == lead) ? lead + 1'b1 : dst;
      end
      ST_HOLD:  stat.done = 1'b1;
      default: begin
        ra = lead;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/grid_path_residue_counter.sv */
// Top level of the grid path residue counter: APB registers, cell and count ports.
// Depends on gprc_pkg and gprc_core (which uses gprc_residue and gprc_addmod).
//
// Configuration: APB, residue_modulus (k) at 0x0 and row_width at 0x4, both reset
//   to 1; write only while the block is idle. k = 0 acts as 1, k above MAX_K as
//   MAX_K; width 0 acts as 1, width above MAX_COLS as MAX_COLS.
// Cell channel: cell_value / last_cell, one cell per beat in row-major order,
//   taken when cell_valid is high and cell_stall low.
// Count channel: one path_count beat per cell flagged last_cell: paths whose sum
//   is divisible by k, mod 1000000007.
// Timing per cell: ST_DIV runs the bit-serial value mod k and sees it finish,
//   ST_ISSUE starts the line-store read, then ST_RUN takes the k residues
//   through the shared modular adder, one residue each. cell_stall is high
//   from each beat until the sweep ends, so no cell goes in before the last
//   one is done; a last cell's count waits in ST_HOLD for the output register.
// Receiver stall: the output register holds the count; cells keep flowing, and
//   only the next last cell waits at the end of its sweep until the register drains.
// Reset: position goes to the top-left cell, left vector reads as zero via valid
//   bits; the line store needs no clearing pass (written in the row above first).
`timescale 1ns / 1ps
`default_nettype none

module grid_path_residue_counter #(
  parameter int MAX_COLS = 256,
  parameter int MAX_K    = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // cell channel
  input  logic                       cell_valid,
  output logic                       cell_stall,
  input  logic [gprc_pkg::VAL_W-1:0] cell_value,
  input  logic                       last_cell,
  // count channel
  output logic                       count_valid,
  input  logic                       count_stall,
  output logic [gprc_pkg::CNT_W-1:0] path_count
);
  import gprc_pkg::*;

  logic [RM_W-1:0]  residue_modulus;
  logic [RW_W-1:0]  row_width;
  logic             cfg_wr;
  logic             start;
  logic             push_ok;
  logic             load;
  core_stat_t       stat;
  logic [CNT_W-1:0] result;

  // ---- APB registers ----
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      residue_modulus <= RM_W'(1);
      row_width       <= RW_W'(1);
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_RESIDUE_MODULUS: residue_modulus <= pwdata[RM_W-1:0];
        REG_ROW_WIDTH:       row_width       <= pwdata[RW_W-1:0];
        default: begin
          row_width <= row_width;
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_RESIDUE_MODULUS: prdata = 32'(residue_modulus);
      REG_ROW_WIDTH:       prdata = 32'(row_width);
      default:             prdata = '0;
    endcase
  end

  // ---- cell beat into the sequencer ----
  assign cell_stall = !stat.idle;
  assign start      = cell_valid && !cell_stall;

  gprc_core #(
    .MAX_COLS (MAX_COLS),
    .MAX_K    (MAX_K)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .cell_value      (cell_value),
    .last_cell       (last_cell),
    .residue_modulus (residue_modulus),
    .row_width       (row_width),
    .push_ok         (push_ok),
    .stat            (stat),
    .result          (result)
  );

  // ---- output register: frees the core while the receiver stalls ----
  assign push_ok = !count_valid || !count_stall;
  assign load    = stat.done && push_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (load) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      path_count <= result;
    end
  end

endmodule

`default_nettype wire

/* rtl/gprc_check.sv */
// Port-level checks for the grid path residue counter, bound to the top level.
// Depends on gprc_pkg and grid_path_residue_counter.
`timescale 1ns / 1ps
`default_nettype none

module gprc_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       cell_valid,
  input logic                       cell_stall,
  input logic                       count_valid,
  input logic                       count_stall,
  input logic [gprc_pkg::CNT_W-1:0] path_count
);
  import gprc_pkg::*;

  // a stalled count beat holds
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    count_valid && count_stall |=> count_valid && $stable(path_count))
    else $error("count beat changed while stalled");

  // counts stay reduced
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count_valid |-> path_count < COUNT_MOD)
    else $error("path_count not reduced");

  // the sequencer is busy through the remainder steps after a cell beat
  a_busy_after_cell: assert property (@(posedge clk) disable iff (rst)
    cell_valid && !cell_stall |=> cell_stall ##7 cell_stall)
    else $error("cell taken while sequencer busy");

  // a count only appears at the end of a sweep
  a_count_from_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(count_valid) |-> $past(cell_stall))
    else $error("count appeared without a sweep");

endmodule

bind grid_path_residue_counter gprc_check u_gprc_check (
  .clk         (clk),
  .rst         (rst),
  .cell_valid  (cell_valid),
  .cell_stall  (cell_stall),
  .count_valid (count_valid),
  .count_stall (count_stall),
  .path_count  (path_count)
);

`default_nettype wire
